@@ sv/pfai_pkg.sv @@
// ----------------------------------------------------------------------------
// pfai_pkg
// Request kinds, pixel-row constants and the row mask helper for the
// page frame buffer area invert block.
// ----------------------------------------------------------------------------
package pfai_pkg;

  localparam logic [1:0] KIND_INVERT = 2'd0;
  localparam logic [1:0] KIND_CLEAR  = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;
  localparam logic [1:0] KIND_NOP    = 2'd3;

  localparam int          ROW_BITS  = 3;      // pixel rows per page byte = 8
  localparam logic [7:0]  BYTE_ONES = 8'hFF;
  localparam logic [7:0]  BYTE_ZERO = 8'h00;
  localparam logic [2:0]  ROW_TOP   = 3'd0;
  localparam logic [2:0]  ROW_BOT   = 3'd7;

  // Bits lo..hi set, lo <= hi.
  function automatic logic [7:0] row_mask(input logic [2:0] lo, input logic [2:0] hi);
    logic [7:0] m;
    m = (BYTE_ONES << lo) & (BYTE_ONES >> (ROW_BOT - hi));
    return m;
  endfunction

endpackage

@@ sv/pfai_ram.sv @@
// ----------------------------------------------------------------------------
// pfai_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered (old data on a same-address collision).
// ----------------------------------------------------------------------------
module pfai_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/page_framebuffer_area_invert.sv @@
// ----------------------------------------------------------------------------
// page_framebuffer_area_invert
// Monochrome page frame store with rectangle invert, clear and byte read-back.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request: kind, the two
//   rectangle corners and the read address. Output channel (out_valid /
//   out_stall) returns exactly one result per request: pixel_byte and op_done.
//   Work per request, on the single read-modify-write port pair of the
//   frame store RAM (one byte touched per cycle):
//     invert : reads and writes back every byte of the W columns in range
//              on the P pages touched; an empty area goes to the result load
//     clear  : one zero write per cycle over all COLUMNS*PAGES bytes
//     read   : read issue, data capture, result load
//     no-op  : result load only
//   The block works on one request at a time; in_stall is low only when the
//   engine is idle and the last invert write-back has landed. A finished
//   result waits in the output register, so the next request can be taken
//   while the receiver holds out_stall; a second result then waits inside
//   the engine until the register frees.
//   Reset: a clearing pass writes zero to all COLUMNS*PAGES bytes, one per
//   cycle, with in_stall high until the pass is over.
// ----------------------------------------------------------------------------
module page_framebuffer_area_invert
  import pfai_pkg::*;
#(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] kind,
  input  logic [7:0] x_start,
  input  logic [7:0] y_start,
  input  logic [7:0] x_end,
  input  logic [7:0] y_end,
  input  logic [6:0] read_column,
  input  logic [2:0] read_page,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] pixel_byte,
  output logic       op_done
);

  localparam int DEPTH = COLUMNS * PAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(COLUMNS);
  localparam int PGW   = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int ROWS  = PAGES * 8;

  localparam logic [7:0]    COL_MAX   = 8'(COLUMNS - 1);
  localparam logic [7:0]    ROW_MAX   = 8'(ROWS - 1);
  localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);

  // Engine states
  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_INV    = 3'd2;
  localparam logic [2:0] S_CLEAR  = 3'd3;
  localparam logic [2:0] S_RDDATA = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state, state_next;

  // Scan registers for the invert walk
  logic [CW-1:0]  col_first, col_last, col_cnt;
  logic [PGW-1:0] pg_first, pg_last, pg_cnt;
  logic [2:0]     row_first, row_last;

  // Clear pass address
  logic [AW-1:0] clr_addr;

  // Pending write-back of a read-modify-write
  logic          wb_valid;
  logic [AW-1:0] wb_addr;
  logic [7:0]    wb_mask;

  // Result waiting to enter the output register
  logic [7:0] res_byte;
  logic       res_done;

  // RAM ports
  logic          ram_wr_en, ram_rd_en;
  logic [AW-1:0] ram_wr_addr, ram_rd_addr;
  logic [7:0]    ram_wr_data, ram_rd_data;

  pfai_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Accept only when idle and no write-back is still in flight, so a read
  // request never sees a stale byte.
  logic accept;
  assign in_stall = !((state == S_IDLE) && !wb_valid);
  assign accept   = in_valid && !in_stall;

  // Order the corners, then clamp the end corner to the panel.
  logic [7:0] x_lo, x_hi, x_hi_c, y_lo, y_hi, y_hi_c;
  logic       area_empty;
  always_comb begin
    x_lo       = (x_start > x_end) ? x_end : x_start;
    x_hi       = (x_start > x_end) ? x_start : x_end;
    y_lo       = (y_start > y_end) ? y_end : y_start;
    y_hi       = (y_start > y_end) ? y_start : y_end;
    x_hi_c     = (x_hi > COL_MAX) ? COL_MAX : x_hi;
    y_hi_c     = (y_hi > ROW_MAX) ? ROW_MAX : y_hi;
    area_empty = (x_lo > x_hi_c) || (y_lo > y_hi_c);
  end

  // Read request address check
  logic          read_in_range;
  logic [AW-1:0] read_addr;
  assign read_in_range = (9'(read_column) < 9'(COLUMNS)) && (5'(read_page) < 5'(PAGES));
  assign read_addr     = AW'(AW'(read_column) * AW'(PAGES) + AW'(read_page));

  // Current scan byte and its mask
  logic [AW-1:0] scan_addr;
  logic [7:0]    scan_mask;
  logic          col_at_end, pg_at_end;
  always_comb begin
    scan_addr  = AW'(AW'(col_cnt) * AW'(PAGES) + AW'(pg_cnt));
    scan_mask  = row_mask((pg_cnt == pg_first) ? row_first : ROW_TOP,
                          (pg_cnt == pg_last)  ? row_last  : ROW_BOT);
    col_at_end = (col_cnt == col_last);
    pg_at_end  = (pg_cnt == pg_last);
  end

  // RAM port steering: scan or read-request reads; write-back, clear pass, or idle.
  always_comb begin
    ram_rd_en   = 1'b0;
    ram_rd_addr = scan_addr;
    if (state == S_INV) begin
      ram_rd_en = 1'b1;
    end else if (accept && (kind == KIND_READ) && read_in_range) begin
      ram_rd_en   = 1'b1;
      ram_rd_addr = read_addr;
    end

    if (wb_valid) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = wb_addr;
      ram_wr_data = ram_rd_data ^ wb_mask;
    end else begin
      ram_wr_en   = (state == S_INIT) || (state == S_CLEAR);
      ram_wr_addr = clr_addr;
      ram_wr_data = BYTE_ZERO;
    end
  end

  // Next state
  logic out_free;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (clr_addr == ADDR_LAST) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_INVERT: state_next = area_empty ? S_DONE : S_INV;
            KIND_CLEAR:  state_next = S_CLEAR;
            KIND_READ:   state_next = read_in_range ? S_RDDATA : S_DONE;
            default:     state_next = S_DONE;
          endcase
        end
      end
      S_INV: begin
        if (col_at_end && pg_at_end) state_next = S_DONE;
      end
      S_CLEAR: begin
        if (clr_addr == ADDR_LAST) state_next = S_DONE;
      end
      S_RDDATA: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      clr_addr <= '0;
      wb_valid <= 1'b0;
    end else begin
      state    <= state_next;
      wb_valid <= (state == S_INV);
      if ((state == S_INIT) || (state == S_CLEAR)) begin
        clr_addr <= (clr_addr == ADDR_LAST) ? '0 : clr_addr + 1'b1;
      end
    end
  end

  // Scan, write-back and result payload
  always_ff @(posedge clk) begin
    wb_addr <= scan_addr;
    wb_mask <= scan_mask;

    if (accept) begin
      col_first <= CW'(x_lo);
      col_last  <= CW'(x_hi_c);
      col_cnt   <= CW'(x_lo);
      pg_first  <= PGW'(y_lo >> ROW_BITS);
      pg_last   <= PGW'(y_hi_c >> ROW_BITS);
      pg_cnt    <= PGW'(y_lo >> ROW_BITS);
      row_first <= y_lo[2:0];
      row_last  <= y_hi_c[2:0];
      res_byte  <= BYTE_ZERO;
      res_done  <= (kind != KIND_NOP);
    end else if (state == S_INV) begin
      // Advance column first, then page.
      if (col_at_end) begin
        col_cnt <= col_first;
        pg_cnt  <= pg_cnt + 1'b1;
      end else begin
        col_cnt <= col_cnt + 1'b1;
      end
    end else if (state == S_RDDATA) begin
      res_byte <= ram_rd_data;
    end
  end

  // Output register: load when the engine finishes and the slot frees.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      pixel_byte <= res_byte;
      op_done    <= res_done;
    end
  end

endmodule

@@ verif/tb_page_framebuffer_area_invert.sv @@
// ----------------------------------------------------------------------------
// Page frame buffer area invert testbench
// Checks the frame store's rectangle invert, clear and byte read-back against
// a cycle-free model of the store. A short table of hand-picked requests comes
// first: corner swaps, empty areas, clamping, page-crossing masks and no-ops.
// Several hundred random requests follow, sent in bursts while the receiver
// stalls on its own pattern.
// ----------------------------------------------------------------------------
module testbench;
  import pfai_pkg::*;

  localparam int NUM_COLS        = 128;
  localparam int NUM_PAGES       = 8;
  localparam int NUM_ROWS        = NUM_PAGES * 8;
  localparam int RANDOM_REQUESTS = 556;
  localparam int HOLD_CYCLES     = 320;   // long receiver hold-off
  localparam int QUIET_LIMIT     = 8000;  // several full-panel passes plus hold-off
  localparam int SETTLE_CYCLES   = 24;
  localparam int PRINT_CAP       = 50;

  // One request as driven, plus an optional hand-typed expectation.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] x0;
    logic [7:0] y0;
    logic [7:0] x1;
    logic [7:0] y1;
    logic [6:0] col;
    logic [2:0] page;
    logic       fixed;
    logic [7:0] fixed_byte;
    logic       fixed_done;
  } request_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       done;
  } result_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] kind;
  logic [7:0] x_start;
  logic [7:0] y_start;
  logic [7:0] x_end;
  logic [7:0] y_end;
  logic [6:0] read_column;
  logic [2:0] read_page;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] pixel_byte;
  logic       op_done;

  // Shadow copy of the panel picture, indexed [column][page].
  logic [7:0] shadow_store [NUM_COLS][NUM_PAGES];
  // Results still owed by the block, oldest first.
  result_t    owed_results [$];

  int  err_count;
  int  results_seen;
  int  n_invert;
  int  n_clear;
  int  n_read;
  int  n_nop;
  int  n_holds;
  int  n_drains;
  int  burst_left;
  bit  hold_req;

  page_framebuffer_area_invert uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .x_start     (x_start),
    .y_start     (y_start),
    .x_end       (x_end),
    .y_end       (y_end),
    .read_column (read_column),
    .read_page   (read_page),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_byte  (pixel_byte),
    .op_done     (op_done)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic request_t mk_req(input logic [1:0] k, input logic [7:0] xa,
                                      input logic [7:0] ya, input logic [7:0] xb,
                                      input logic [7:0] yb, input logic [6:0] c,
                                      input logic [2:0] p, input logic fx,
                                      input logic [7:0] fb, input logic fd);
    request_t r;
    r.kind       = k;
    r.x0         = xa;
    r.y0         = ya;
    r.x1         = xb;
    r.y1         = yb;
    r.col        = c;
    r.page       = p;
    r.fixed      = fx;
    r.fixed_byte = fb;
    r.fixed_done = fd;
    return r;
  endfunction

  // Apply one request to the shadow store and return the result it owes.
  function automatic result_t frame_apply(input request_t r);
    result_t    res;
    int         xa, xb, ya, yb, t;
    int         first_pg, last_pg, lo, hi, pg, b, c;
    logic [7:0] mask;
    res.pixel = BYTE_ZERO;
    res.done  = 1'b1;
    case (r.kind)
      KIND_INVERT: begin
        xa = int'(r.x0);
        xb = int'(r.x1);
        ya = int'(r.y0);
        yb = int'(r.y1);
        // Order the corners first, clamp the far corner afterwards.
        if (xa > xb) begin
          t = xa; xa = xb; xb = t;
        end
        if (ya > yb) begin
          t = ya; ya = yb; yb = t;
        end
        if (xb > NUM_COLS - 1) xb = NUM_COLS - 1;
        if (yb > NUM_ROWS - 1) yb = NUM_ROWS - 1;
        // A start beyond the clamped end leaves the picture alone.
        if (xa <= xb && ya <= yb) begin
          first_pg = ya / 8;
          last_pg  = yb / 8;
          for (pg = first_pg; pg <= last_pg; pg++) begin
            lo   = (pg == first_pg) ? ya % 8 : 0;
            hi   = (pg == last_pg) ? yb % 8 : 7;
            mask = BYTE_ZERO;
            for (b = lo; b <= hi; b++) mask[b] = 1'b1;
            for (c = xa; c <= xb; c++) shadow_store[c][pg] ^= mask;
          end
        end
      end
      KIND_CLEAR: begin
        for (c = 0; c < NUM_COLS; c++)
          for (pg = 0; pg < NUM_PAGES; pg++) shadow_store[c][pg] = BYTE_ZERO;
      end
      KIND_READ: begin
        res.pixel = shadow_store[r.col][r.page];
      end
      default: begin
        res.done = 1'b0;
      end
    endcase
    return res;
  endfunction

  // Draw one random request: mostly reads and small rectangles, with a few
  // wild corners, near-full panels, clears and no-ops mixed in.
  function automatic request_t random_request();
    request_t   r;
    int         roll;
    logic [7:0] t;
    r = mk_req(KIND_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               7'($urandom_range(0, NUM_COLS - 1)),
               3'($urandom_range(0, NUM_PAGES - 1)),
               1'b0, BYTE_ZERO, 1'b0);
    roll = $urandom_range(0, 99);
    if (roll < 44) begin
      r.kind = KIND_READ;
    end else if (roll < 84) begin
      r.kind = KIND_INVERT;
      r.x0   = 8'($urandom_range(0, NUM_COLS - 1));
      r.x1   = r.x0 + 8'($urandom_range(0, 12));
      r.y0   = 8'($urandom_range(0, NUM_ROWS - 1));
      r.y1   = r.y0 + 8'($urandom_range(0, 14));
      if ($urandom_range(0, 1)) begin
        t = r.x0; r.x0 = r.x1; r.x1 = t;
      end
      if ($urandom_range(0, 1)) begin
        t = r.y0; r.y0 = r.y1; r.y1 = t;
      end
    end else if (roll < 91) begin
      r.kind = KIND_INVERT;   // corners anywhere in the byte range
    end else if (roll < 94) begin
      r.kind = KIND_INVERT;
      r.x0   = 8'($urandom_range(0, 3));
      r.x1   = 8'($urandom_range(NUM_COLS - 8, 255));
      r.y0   = 8'($urandom_range(0, 7));
      r.y1   = 8'($urandom_range(NUM_ROWS - 8, 255));
      if ($urandom_range(0, 1)) begin
        t = r.x0; r.x0 = r.x1; r.x1 = t;
      end
    end else if (roll < 98) begin
      r.kind = KIND_CLEAR;
    end else begin
      r.kind = KIND_NOP;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    err_count++;
    if (err_count <= PRINT_CAP)
      $display("mismatch at result %0d: %s got 0x%02h want 0x%02h",
               results_seen, what, got, want);
  endtask

  // Offer one request, hold it until accepted, then log what it owes.
  // Between bursts, drop valid for a random gap first.
  task automatic send_request(input request_t r);
    result_t want;
    int      gap;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(60, 140);
      else burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid    <= 1'b1;
    kind        <= r.kind;
    x_start     <= r.x0;
    y_start     <= r.y0;
    x_end       <= r.x1;
    y_end       <= r.y1;
    read_column <= r.col;
    read_page   <= r.page;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    want = frame_apply(r);
    if (r.fixed) begin
      want.pixel = r.fixed_byte;
      want.done  = r.fixed_done;
    end
    owed_results.push_back(want);
    case (r.kind)
      KIND_INVERT: n_invert++;
      KIND_CLEAR:  n_clear++;
      KIND_READ:   n_read++;
      default:     n_nop++;
    endcase
  endtask

  // Stop offering and wait until every owed result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    n_drains++;
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  // Result side: match every accepted result against the oldest owed one.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        report_mismatch("result with none owed, pixel_byte", pixel_byte, BYTE_ZERO);
      end else begin
        want = owed_results.pop_front();
        if (pixel_byte !== want.pixel) report_mismatch("pixel_byte", pixel_byte, want.pixel);
        if (op_done !== want.done)
          report_mismatch("op_done", {7'd0, op_done}, {7'd0, want.done});
      end
    end
  end

  // Receiver: stall with a duty that changes from segment to segment, some
  // segments not at all. On request, hold off for a long stretch so the block
  // backs up and stalls its input.
  initial begin : result_sink
    int seg;
    int pct;
    out_stall = 1'b0;
    forever begin
      seg = $urandom_range(8, 80);
      case ($urandom_range(0, 4))
        0:       pct = 0;
        1:       pct = 20;
        2:       pct = 50;
        3:       pct = 85;
        default: pct = 35;
      endcase
      repeat (seg) begin
        @(posedge clk);
        if (hold_req) begin
          hold_req = 1'b0;
          n_holds++;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    request_t dir_tab [$];
    rst          = 1'b1;
    in_valid     = 1'b0;
    kind         = KIND_NOP;
    x_start      = 8'd0;
    y_start      = 8'd0;
    x_end        = 8'd0;
    y_end        = 8'd0;
    read_column  = 7'd0;
    read_page    = 3'd0;
    err_count    = 0;
    results_seen = 0;
    n_invert     = 0;
    n_clear      = 0;
    n_read       = 0;
    n_nop        = 0;
    n_holds      = 0;
    n_drains     = 0;
    burst_left   = 0;
    hold_req     = 1'b0;
    for (int c = 0; c < NUM_COLS; c++)
      for (int p = 0; p < NUM_PAGES; p++) shadow_store[c][p] = BYTE_ZERO;

    // Directed table. Rows with fixed=1 carry a hand-typed result; the
    // rest are checked against the shadow store.
    // Store is blank after reset, at both far corners.
    dir_tab.push_back(mk_req(KIND_READ,   0,   0,   0,   0,   0, 0, 1, 8'h00, 1));
    dir_tab.push_back(mk_req(KIND_READ,   0,   0,   0,   0, 127, 7, 1, 8'h00, 1));
    // Full panel with corners far past the edge: clamp to the whole screen.
    dir_tab.push_back(mk_req(KIND_INVERT, 0,   0, 255, 255,   0, 0, 1, 8'h00, 1));
    dir_tab.push_back(mk_req(KIND_READ,   0,   0,   0,   0, 127, 7, 1, 8'hFF, 1));
    dir_tab.push_back(mk_req(KIND_READ,   0,   0,   0,   0,   0, 0, 1, 8'hFF, 1));
    dir_tab.push_back(mk_req(KIND_READ,   0,   0,   0,   0,  64, 3, 1, 8'hFF, 1));
    dir_tab.push_back(mk_req(KIND_CLEAR,  0,   0,   0,   0,   0, 0, 1, 8'h00, 1));
    dir_tab.push_back(mk_req(KIND_READ,   0,   0,   0,   0,  64, 3, 1, 8'h00, 1));
    // Swapped corners on both axes, spanning two pages.
    dir_tab.push_back(mk_req(KIND_INVERT, 20, 13, 10,  2,   0, 0, 0, 8'h00, 0));
    dir_tab.push_back(mk_req(KIND_READ,   0,   0,   0,   0,  15, 0, 0, 8'h00, 0));
    dir_tab.push_back(mk_req(KIND_READ,   0,   0,   0,   0,  15, 1, 0, 8'h00, 0));
    dir_tab.push_back(mk_req(KIND_READ,   0,   0,   0,   0,  21, 0, 0, 8'h00, 0));
    // Start column past the panel, then start row past the panel: empty.
    dir_tab.push_back(mk_req(KIND_INVERT, 200, 0, 255,  63,   0, 0, 1, 8'h00, 1));
    dir_tab.push_back(mk_req(KIND_INVERT, 0, 100, 127,  64,   0, 0, 1, 8'h00, 1));
    dir_tab.push_back(mk_req(KIND_READ,   0,   0,   0,   0, 127, 7, 0, 8'h00, 0));
    // Single bottom-right pixel lands in bit 7 of the last byte.
    dir_tab.push_back(mk_req(KIND_INVERT, 127, 63, 127, 63,   0, 0, 1, 8'h00, 1));
    dir_tab.push_back(mk_req(KIND_READ,   0,   0,   0,   0, 127, 7, 1, 8'h80, 1));
    // Unused kind: nothing done, op_done low.
    dir_tab.push_back(mk_req(KIND_NOP,    0,   0,   0,   0,   0, 0, 1, 8'h00, 0));
    // Swapped columns with the far one clamped: full-width top page.
    dir_tab.push_back(mk_req(KIND_INVERT, 255, 0,   0,   7,   0, 0, 0, 8'h00, 0));
    dir_tab.push_back(mk_req(KIND_READ,   0,   0,   0,   0,   0, 0, 0, 8'h00, 0));
    dir_tab.push_back(mk_req(KIND_READ,   0,   0,   0,   0, 127, 0, 0, 8'h00, 0));
    // Rows 7..8 straddle a page boundary: one bit in each page.
    dir_tab.push_back(mk_req(KIND_INVERT, 1,   7,   2,   8,   0, 0, 0, 8'h00, 0));
    dir_tab.push_back(mk_req(KIND_READ,   0,   0,   0,   0,   1, 0, 0, 8'h00, 0));
    dir_tab.push_back(mk_req(KIND_READ,   0,   0,   0,   0,   2, 1, 0, 8'h00, 0));
    dir_tab.push_back(mk_req(KIND_CLEAR,  0,   0,   0,   0,   0, 0, 1, 8'h00, 1));
    dir_tab.push_back(mk_req(KIND_READ,   0,   0,   0,   0,   1, 0, 1, 8'h00, 1));

    // Hold reset, then release it; the block's clearing pass keeps the
    // input stalled for a while, which the handshake absorbs.
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) send_request(dir_tab[i]);
    drain_results();

    // Random phase. Pause twice for a full drain; once ask the receiver to
    // hold off while requests keep coming.
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == 150 || i == 420) drain_results();
      if (i == 260) hold_req = 1'b1;
      send_request(random_request());
    end
    in_valid <= 1'b0;

    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d invert, %0d clear, %0d read, %0d no-op",
             n_invert + n_clear + n_read + n_nop, n_invert, n_clear, n_read, n_nop);
    $display("checked %0d results across %0d hold-offs and %0d drain pauses, %0d mismatches",
             results_seen, n_holds, n_drains, err_count);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
